### hw/rtl/cst_pkg.sv
package cst_pkg;

    // Position counter width; positions wrap at 2**POS_BITS
    localparam int POS_BITS  = 16;
    localparam int OUT_POS_W = 16;
    localparam int KIND_W    = 5;
    localparam int MAX_RES   = 3;
    localparam int CNT_W     = 2;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;

    typedef logic [POS_BITS-1:0]  t_pos;
    typedef logic [OUT_POS_W-1:0] t_out_pos;
    typedef logic [KIND_W-1:0]    t_kind;

    localparam t_kind KIND_END    = 5'd0;
    localparam t_kind KIND_NUM    = 5'd1;
    localparam t_kind KIND_IDENT  = 5'd2;
    localparam t_kind KIND_COLON  = 5'd3;
    localparam t_kind KIND_DOT    = 5'd4;
    localparam t_kind KIND_LBRK   = 5'd5;
    localparam t_kind KIND_RBRK   = 5'd6;
    localparam t_kind KIND_BTICK  = 5'd7;
    localparam t_kind KIND_UNDER  = 5'd8;
    localparam t_kind KIND_GT     = 5'd9;
    localparam t_kind KIND_LT     = 5'd10;
    localparam t_kind KIND_PLUS   = 5'd11;
    localparam t_kind KIND_MINUS  = 5'd12;
    localparam t_kind KIND_STAR   = 5'd13;
    localparam t_kind KIND_SLASH  = 5'd14;
    localparam t_kind KIND_QUOTE  = 5'd15;
    localparam t_kind KIND_DQUOTE = 5'd16;
    localparam t_kind KIND_EQ     = 5'd17;
    localparam t_kind KIND_GTE    = 5'd18;
    localparam t_kind KIND_LTE    = 5'd19;
    localparam t_kind KIND_ERR    = 5'd20;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NUM,
        MODE_IDENT,
        MODE_GT,
        MODE_LT
    } t_mode;

    typedef struct packed {
        t_mode mode;
        t_pos  pos;
        t_pos  tok_begin;
        logic  halted;
    } t_scan_state;

    typedef struct packed {
        t_kind    kind;
        t_out_pos start_pos;
        t_out_pos end_pos;
    } t_token;

    // All tokens caused by one character transaction
    typedef struct packed {
        logic [CNT_W-1:0]         count;
        t_token [MAX_RES-1:0]     tok;
    } t_bundle;

    function automatic t_token mk_tok(t_kind k, t_pos s, t_pos e);
        t_token t;
        t.kind      = k;
        t.start_pos = OUT_POS_W'(s);
        t.end_pos   = OUT_POS_W'(e);
        return t;
    endfunction

endpackage

### hw/rtl/cst_char_if.sv
interface cst_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       char_present;
    logic       end_of_source;

    modport source (output valid, output char_code, output char_present,
                    output end_of_source, input ready);
    modport sink   (input valid, input char_code, input char_present,
                    input end_of_source, output ready);
endinterface

### hw/rtl/cst_tok_if.sv
interface cst_tok_if;
    logic                          valid;
    logic                          ready;
    logic [cst_pkg::KIND_W-1:0]    lex_kind;
    logic [cst_pkg::OUT_POS_W-1:0] start_pos;
    logic [cst_pkg::OUT_POS_W-1:0] end_pos;
    logic                          last_of_run;

    modport source (output valid, output lex_kind, output start_pos,
                    output end_pos, output last_of_run, input ready);
    modport sink   (input valid, input lex_kind, input start_pos,
                    input end_pos, input last_of_run, output ready);
endinterface

### hw/rtl/cst_step.sv
module cst_step (
    input  cst_pkg::t_scan_state i_state,
    input  logic [7:0]           i_char_code,
    input  logic                 i_char_present,
    input  logic                 i_end_of_source,
    output cst_pkg::t_scan_state o_state,
    output cst_pkg::t_bundle     o_bundle
);
    import cst_pkg::*;

    localparam logic [7:0] CH_EQ = 8'h3D;
    localparam logic [7:0] CH_GT = 8'h3E;
    localparam logic [7:0] CH_LT = 8'h3C;
    localparam logic [7:0] CH_US = 8'h5F;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    // KIND_ERR marks a byte outside the punctuation set
    function automatic t_kind punct_kind(logic [7:0] c);
        t_kind k;
        case (c)
            8'h3A:   k = KIND_COLON;
            8'h2E:   k = KIND_DOT;
            8'h5B:   k = KIND_LBRK;
            8'h5D:   k = KIND_RBRK;
            8'h60:   k = KIND_BTICK;
            8'h5F:   k = KIND_UNDER;
            8'h3E:   k = KIND_GT;
            8'h3C:   k = KIND_LT;
            8'h2B:   k = KIND_PLUS;
            8'h2D:   k = KIND_MINUS;
            8'h2A:   k = KIND_STAR;
            8'h2F:   k = KIND_SLASH;
            8'h27:   k = KIND_QUOTE;
            8'h22:   k = KIND_DQUOTE;
            8'h3D:   k = KIND_EQ;
            default: k = KIND_ERR;
        endcase
        return k;
    endfunction

    t_scan_state      ns;
    t_bundle          b;
    logic [CNT_W-1:0] n;
    logic             done;
    t_pos             p;
    t_kind            pk;
    logic [7:0]       c;

    assign c  = i_char_code;
    assign p  = i_state.pos;
    assign pk = punct_kind(i_char_code);

    always_comb begin
        ns   = i_state;
        b    = '0;
        n    = '0;
        done = 1'b0;
        if (!i_state.halted) begin
            if (i_char_present) begin
                // close or continue the open run
                case (i_state.mode)
                    MODE_NUM: begin
                        if (is_digit(c)) begin
                            done = 1'b1;
                        end else begin
                            b.tok[n] = mk_tok(KIND_NUM, i_state.tok_begin, p);
                            n = n + 1'b1;
                            ns.mode = MODE_IDLE;
                        end
                    end
                    MODE_IDENT: begin
                        if (is_alpha(c) || is_digit(c) || (c == CH_US)) begin
                            done = 1'b1;
                        end else begin
                            b.tok[n] = mk_tok(KIND_IDENT, i_state.tok_begin, p);
                            n = n + 1'b1;
                            ns.mode = MODE_IDLE;
                        end
                    end
                    MODE_GT, MODE_LT: begin
                        ns.mode = MODE_IDLE;
                        if (c == CH_EQ) begin
                            b.tok[n] = mk_tok((i_state.mode == MODE_GT) ? KIND_GTE : KIND_LTE,
                                              i_state.tok_begin, p + 1'b1);
                            n = n + 1'b1;
                            done = 1'b1;
                        end else begin
                            b.tok[n] = mk_tok((i_state.mode == MODE_GT) ? KIND_GT : KIND_LT,
                                              i_state.tok_begin, i_state.tok_begin + 1'b1);
                            n = n + 1'b1;
                        end
                    end
                    default: ns.mode = MODE_IDLE;
                endcase

                // start a new token from idle
                if (!done) begin
                    if (is_space(c)) begin
                        ns.mode = MODE_IDLE;
                    end else if (is_digit(c)) begin
                        ns.mode      = MODE_NUM;
                        ns.tok_begin = p;
                    end else if (pk != KIND_ERR) begin
                        if (c == CH_GT) begin
                            ns.mode      = MODE_GT;
                            ns.tok_begin = p;
                        end else if (c == CH_LT) begin
                            ns.mode      = MODE_LT;
                            ns.tok_begin = p;
                        end else begin
                            b.tok[n] = mk_tok(pk, p, p + 1'b1);
                            n = n + 1'b1;
                        end
                    end else if (is_alpha(c)) begin
                        ns.mode      = MODE_IDENT;
                        ns.tok_begin = p;
                    end else begin
                        b.tok[n] = mk_tok(KIND_ERR, p, p + 1'b1);
                        n = n + 1'b1;
                        ns.halted = 1'b1;
                    end
                end
                ns.pos = p + 1'b1;
            end

            if (i_end_of_source && !ns.halted) begin
                case (ns.mode)
                    MODE_NUM: begin
                        b.tok[n] = mk_tok(KIND_NUM, ns.tok_begin, ns.pos);
                        n = n + 1'b1;
                    end
                    MODE_IDENT: begin
                        b.tok[n] = mk_tok(KIND_IDENT, ns.tok_begin, ns.pos);
                        n = n + 1'b1;
                    end
                    MODE_GT: begin
                        b.tok[n] = mk_tok(KIND_GT, ns.tok_begin, ns.tok_begin + 1'b1);
                        n = n + 1'b1;
                    end
                    MODE_LT: begin
                        b.tok[n] = mk_tok(KIND_LT, ns.tok_begin, ns.tok_begin + 1'b1);
                        n = n + 1'b1;
                    end
                    default: ;
                endcase
                b.tok[n]     = mk_tok(KIND_END, ns.pos, ns.pos);
                n            = n + 1'b1;
                ns.mode      = MODE_IDLE;
                ns.pos       = '0;
                ns.tok_begin = '0;
            end
        end
        b.count = n;
    end

    assign o_state  = ns;
    assign o_bundle = b;

endmodule

### hw/rtl/cst_tok_fifo.sv
module cst_tok_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  cst_pkg::t_bundle i_bundle,
    output logic             o_full,
    output logic             o_valid,
    output cst_pkg::t_token  o_token,
    output logic             o_last,
    input  logic             i_pop
);
    import cst_pkg::*;

    t_bundle           r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic [CNT_W-1:0]  r_sub;
    t_bundle           head;
    logic              pop_bundle;

    assign head       = r_mem[r_rd_ptr];
    assign o_full     = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_valid    = (r_count != '0);
    assign o_token    = head.tok[r_sub];
    assign o_last     = (r_sub == (head.count - 1'b1));
    assign pop_bundle = i_pop && o_valid && o_last;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_sub    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_bundle) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
                r_sub    <= '0;
            end else if (i_pop && o_valid) begin
                r_sub <= r_sub + 1'b1;
            end
            case ({i_push, pop_bundle})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### hw/rtl/char_stream_tokenizer.sv
// Channel  | Dir | Payload                                        | Transaction
// ---------+-----+------------------------------------------------+---------------------
// i_char   | in  | char_code[7:0], char_present, end_of_source    | one source character
// o_tok    | out | lex_kind[4:0], start_pos, end_pos, last_of_run | one token
//
// One character transaction is taken per cycle while the token queue has a free slot;
// its scan is a single pass of logic from the scan state register into the queue.
// Each transaction gives zero to three tokens, delivered one per cycle from the queue while o_tok is ready,
// so the sustained rate is one character per cycle whenever output stays at most one token per character
// and is not stalled; the four-entry queue absorbs bursts and output stalls.
// Synchronous active-low reset clears scan state, halt flag and queue.
module char_stream_tokenizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cst_char_if.sink   i_char,
    cst_tok_if.source  o_tok
);
    import cst_pkg::*;

    t_scan_state r_state;
    t_scan_state n_state;
    t_bundle     step_bundle;
    logic        accept;
    logic        q_full;
    logic        q_valid;
    logic        q_last;
    t_token      q_token;

    // Hold off new characters only when the queue cannot take another bundle
    assign i_char.ready = !q_full;
    assign accept       = i_char.valid && i_char.ready;

    cst_step u_step (
        .i_state         (r_state),
        .i_char_code     (i_char.char_code),
        .i_char_present  (i_char.char_present),
        .i_end_of_source (i_char.end_of_source),
        .o_state         (n_state),
        .o_bundle        (step_bundle)
    );

    // Advance scan state on every accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode      <= MODE_IDLE;
            r_state.pos       <= '0;
            r_state.tok_begin <= '0;
            r_state.halted    <= 1'b0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // Drop empty bundles; queue the rest for delivery
    cst_tok_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (accept && (step_bundle.count != '0)),
        .i_bundle (step_bundle),
        .o_full   (q_full),
        .o_valid  (q_valid),
        .o_token  (q_token),
        .o_last   (q_last),
        .i_pop    (o_tok.ready)
    );

    assign o_tok.valid       = q_valid;
    assign o_tok.lex_kind    = q_token.kind;
    assign o_tok.start_pos   = q_token.start_pos;
    assign o_tok.end_pos     = q_token.end_pos;
    assign o_tok.last_of_run = q_last;

endmodule

### bench/cst_token_checker.sv
`timescale 1ns / 100ps

module cst_token_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_char_valid,
    input  logic              i_char_ready,
    input  logic [7:0]        i_char_code,
    input  logic              i_char_present,
    input  logic              i_char_eos,
    input  logic              i_tok_valid,
    input  logic              i_tok_ready,
    input  cst_pkg::t_kind    i_tok_kind,
    input  cst_pkg::t_out_pos i_tok_start,
    input  cst_pkg::t_out_pos i_tok_end,
    input  logic              i_tok_last,
    output int                o_errors,
    output int                o_pending,
    output int                o_checked
);
    import cst_pkg::*;

    typedef struct {
        t_kind    kind;
        t_out_pos start_pos;
        t_out_pos end_pos;
        logic     last;
    } t_due_token;

    // Scan state mirrored from the character transactions
    t_mode      mode;
    t_pos       pos;
    t_pos       tok_begin;
    logic       halted;
    t_due_token item_tokens[$];
    t_due_token tokens_due[$];
    int         errors;
    int         checked;

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // KIND_ERR marks a byte outside the punctuation set
    function automatic t_kind punct_kind(logic [7:0] c);
        case (c)
            ":":     return KIND_COLON;
            ".":     return KIND_DOT;
            "[":     return KIND_LBRK;
            "]":     return KIND_RBRK;
            8'h60:   return KIND_BTICK;
            "_":     return KIND_UNDER;
            ">":     return KIND_GT;
            "<":     return KIND_LT;
            "+":     return KIND_PLUS;
            "-":     return KIND_MINUS;
            "*":     return KIND_STAR;
            "/":     return KIND_SLASH;
            "'":     return KIND_QUOTE;
            "\"":    return KIND_DQUOTE;
            "=":     return KIND_EQ;
            default: return KIND_ERR;
        endcase
    endfunction

    function void note_token(t_kind k, t_pos s, t_pos e);
        t_due_token t;
        t.kind      = k;
        t.start_pos = t_out_pos'(s);
        t.end_pos   = t_out_pos'(e);
        t.last      = 1'b0;
        item_tokens.push_back(t);
    endfunction

    function void lex_char(logic [7:0] c);
        t_pos  p;
        t_kind k;
        logic  gt;
        p = pos;
        case (mode)
            MODE_NUM: begin
                if (is_digit(c)) return;
                note_token(KIND_NUM, tok_begin, p);
            end
            MODE_IDENT: begin
                if (is_letter(c) || is_digit(c) || c == "_") return;
                note_token(KIND_IDENT, tok_begin, p);
            end
            MODE_GT, MODE_LT: begin
                gt   = (mode == MODE_GT);
                mode = MODE_IDLE;
                if (c == "=") begin
                    note_token(gt ? KIND_GTE : KIND_LTE, tok_begin, t_pos'(p + 1));
                    return;
                end
                note_token(gt ? KIND_GT : KIND_LT, tok_begin, t_pos'(tok_begin + 1));
            end
            default: ;
        endcase
        mode = MODE_IDLE;
        if (is_space(c)) return;
        if (is_digit(c)) begin
            mode      = MODE_NUM;
            tok_begin = p;
            return;
        end
        k = punct_kind(c);
        if (k != KIND_ERR) begin
            if (c == ">" || c == "<") begin
                mode      = (c == ">") ? MODE_GT : MODE_LT;
                tok_begin = p;
            end else begin
                note_token(k, p, t_pos'(p + 1));
            end
            return;
        end
        if (is_letter(c)) begin
            mode      = MODE_IDENT;
            tok_begin = p;
            return;
        end
        note_token(KIND_ERR, p, t_pos'(p + 1));
        halted = 1'b1;
    endfunction

    function void lex_end_of_source();
        case (mode)
            MODE_NUM:   note_token(KIND_NUM, tok_begin, pos);
            MODE_IDENT: note_token(KIND_IDENT, tok_begin, pos);
            MODE_GT:    note_token(KIND_GT, tok_begin, t_pos'(tok_begin + 1));
            MODE_LT:    note_token(KIND_LT, tok_begin, t_pos'(tok_begin + 1));
            default: ;
        endcase
        note_token(KIND_END, pos, pos);
        mode      = MODE_IDLE;
        pos       = '0;
        tok_begin = '0;
    endfunction

    always @(posedge i_clk) begin
        t_due_token due;
        if (!i_rst_n) begin
            mode      = MODE_IDLE;
            pos       = '0;
            tok_begin = '0;
            halted    = 1'b0;
            tokens_due.delete();
            errors    = 0;
            checked   = 0;
        end else begin
            // Tokens leave the queue only after their character has been pushed into it
            if (i_tok_valid && i_tok_ready) begin
                if (tokens_due.size() == 0) begin
                    errors++;
                    if (errors <= 30)
                        $display({"%0t: unexpected token, expected none,",
                                  " got kind %0d [%0d,%0d) last %0b"},
                                 $time, i_tok_kind, i_tok_start, i_tok_end, i_tok_last);
                end else begin
                    due = tokens_due.pop_front();
                    checked++;
                    if (due.kind !== i_tok_kind || due.start_pos !== i_tok_start ||
                        due.end_pos !== i_tok_end || due.last !== i_tok_last) begin
                        errors++;
                        if (errors <= 30)
                            $display({"%0t: token mismatch, expected kind %0d [%0d,%0d) last %0b,",
                                      " got kind %0d [%0d,%0d) last %0b"},
                                     $time, due.kind, due.start_pos, due.end_pos, due.last,
                                     i_tok_kind, i_tok_start, i_tok_end, i_tok_last);
                    end
                end
            end
            if (i_char_valid && i_char_ready && !halted) begin
                item_tokens.delete();
                if (i_char_present) begin
                    lex_char(i_char_code);
                    pos = t_pos'(pos + 1);
                end
                if (i_char_eos && !halted)
                    lex_end_of_source();
                if (item_tokens.size() > 0)
                    item_tokens[item_tokens.size() - 1].last = 1'b1;
                foreach (item_tokens[i])
                    tokens_due.push_back(item_tokens[i]);
            end
        end
        o_errors  <= errors;
        o_pending <= tokens_due.size();
        o_checked <= checked;
    end

endmodule

### bench/tb_char_stream_tokenizer.sv
`timescale 1ns / 100ps

module tb_char_stream_tokenizer;

    logic i_clk;
    logic i_rst_n;

    cst_char_if char_ch();
    cst_tok_if  tok_ch();

    int errors;
    int pending;
    int checked;

    // Idling mix of the current phase, in percent of cycles
    int gap_pct;
    int stall_pct;
    // Transactions that carry a character or an end of source
    int items_sent;

    char_stream_tokenizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_ch),
        .o_tok   (tok_ch)
    );

    // The checker mirrors the scan state and scores every token transaction
    cst_token_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_char_valid   (char_ch.valid),
        .i_char_ready   (char_ch.ready),
        .i_char_code    (char_ch.char_code),
        .i_char_present (char_ch.char_present),
        .i_char_eos     (char_ch.end_of_source),
        .i_tok_valid    (tok_ch.valid),
        .i_tok_ready    (tok_ch.ready),
        .i_tok_kind     (tok_ch.lex_kind),
        .i_tok_start    (tok_ch.start_pos),
        .i_tok_end      (tok_ch.end_pos),
        .i_tok_last     (tok_ch.last_of_run),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #4_000_000;
        $display("tb_char_stream_tokenizer: done, errors");
        $finish;
    end

    // Stall the token side at the rate of the current phase
    always @(posedge i_clk) begin
        tok_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic logic [7:0] rand_letter();
        return $urandom_range(1) ? 8'("a" + $urandom_range(25)) : 8'("A" + $urandom_range(25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(9));
    endfunction

    // Space, tab, newline, vertical tab, form feed or carriage return
    function automatic logic [7:0] rand_space();
        return $urandom_range(5) == 0 ? 8'h20 : 8'(9 + $urandom_range(4));
    endfunction

    function automatic logic [7:0] rand_punct();
        case ($urandom_range(14))
            0:       return ":";
            1:       return ".";
            2:       return "[";
            3:       return "]";
            4:       return 8'h60;
            5:       return "_";
            6:       return ">";
            7:       return "<";
            8:       return "+";
            9:       return "-";
            10:      return "*";
            11:      return "/";
            12:      return "'";
            13:      return "\"";
            default: return "=";
        endcase
    endfunction

    // Drive one character transaction; hold it until the block takes it.
    // Between back-to-back transactions valid stays high rather than being
    // dropped and raised again.
    task automatic send_item(input logic [7:0] code, input logic present, input logic eos);
        while ($urandom_range(99) < gap_pct) begin
            char_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        char_ch.valid         <= 1'b1;
        char_ch.char_code     <= code;
        char_ch.char_present  <= present;
        char_ch.end_of_source <= eos;
        @(posedge i_clk);
        while (!char_ch.ready) @(posedge i_clk);
        if (present || eos) items_sent++;
    endtask

    // Send a string; optionally let its last character end the source
    task automatic send_text(input string s, input logic close);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b1, close && i == s.len() - 1);
    endtask

    // Build one source text from random lexemes, mostly well formed, with
    // adjacent lexemes, empty transactions and abrupt ends mixed in
    task automatic send_random_source();
        logic [8:0] text[$];
        int         n_lex;
        int         len;
        logic       close_on_char;
        n_lex = $urandom_range(8);
        for (int l = 0; l < n_lex; l++) begin
            case ($urandom_range(9))
                0, 1: begin
                    len = $urandom_range(1, 4);
                    repeat (len) text.push_back({1'b1, rand_digit()});
                end
                2, 3: begin
                    text.push_back({1'b1, rand_letter()});
                    len = $urandom_range(4);
                    repeat (len) begin
                        case ($urandom_range(2))
                            0:       text.push_back({1'b1, rand_letter()});
                            1:       text.push_back({1'b1, rand_digit()});
                            default: text.push_back({1'b1, 8'h5F});
                        endcase
                    end
                end
                4, 5: text.push_back({1'b1, rand_punct()});
                6: begin
                    text.push_back({1'b1, $urandom_range(1) ? 8'h3E : 8'h3C});
                    text.push_back({1'b1, 8'h3D});
                end
                7: text.push_back({1'b1, rand_space()});
                // empty transaction: the code is don't-care and must be ignored
                default: text.push_back({1'b0, 8'($urandom)});
            endcase
            if ($urandom_range(9) < 6)
                text.push_back({1'b1, rand_space()});
        end
        close_on_char = text.size() > 0 && text[text.size() - 1][8] && $urandom_range(1);
        foreach (text[i])
            send_item(text[i][7:0], text[i][8], close_on_char && i == text.size() - 1);
        if (!close_on_char)
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    initial begin
        logic [7:0] bad_char;
        int         target;
        char_ch.valid         <= 1'b0;
        char_ch.char_code     <= 8'h00;
        char_ch.char_present  <= 1'b0;
        char_ch.end_of_source <= 1'b0;
        gap_pct    = 0;
        stall_pct  = 0;
        items_sent = 0;
        i_rst_n   <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n   <= 1'b1;

        // Directed source: identifier with underscore and digit, every
        // whitespace byte but the space, underscore at token start, all single punctuation,
        // a number, both merged compares, '>' closed by a letter and a
        // pending '<' closed by the end of source in the same transaction
        send_text("Zz_9\011_:.[]", 1'b0);
        send_item(8'h60, 1'b1, 1'b0);
        send_text("+-*/'\"=\01209\013>=<=\014>a\015<", 1'b1);
        // Empty transaction, then an empty source ended without a character
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        // Identifier closed by an end-only transaction
        send_text("q9", 1'b0);
        send_item(8'hA5, 1'b0, 1'b1);
        // Three tokens from one transaction: pending '>', '+', end
        send_text(">+", 1'b1);
        // Number opened and closed by the same transaction
        send_text("7", 1'b1);

        // Random sources over four idling phases
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 47; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 47; end
                default: begin gap_pct = 9;  stall_pct = 9;  end
            endcase
            target = items_sent + 98;
            while (items_sent < target) send_random_source();
        end

        // Unknown byte closes the open identifier and halts the block
        case ($urandom_range(3))
            0:       bad_char = 8'h00;
            1:       bad_char = 8'($urandom_range(128, 255));
            2:       bad_char = $urandom_range(1) ? 8'h21 : 8'h7E;
            default: bad_char = $urandom_range(1) ? 8'($urandom_range(1, 8)) : 8'h7F;
        endcase
        send_text("ab", 1'b0);
        send_item(bad_char, 1'b1, 1'b0);
        // Everything after the halt, end of source included, is dropped
        gap_pct   = 9;
        stall_pct = 9;
        send_text("9z<", 1'b1);
        send_item(8'h00, 1'b0, 1'b1);
        char_ch.valid <= 1'b0;

        // Drain, then hold a while to catch stray tokens
        @(posedge i_clk);
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Covered %0d character transactions and %0d scored tokens: directed lexemes,",
                 items_sent, checked);
        $display("random sources under four idling phases and the sticky halt.");
        if (errors == 0) begin
            $display("tb_char_stream_tokenizer: done, clean");
        end else begin
            $display("tb_char_stream_tokenizer: done, errors");
        end
        $finish;
    end

endmodule
